### rtl/aspq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aspq_pkg;

	// field widths
	localparam int MODE_W   = 3;
	localparam int ID_W     = 4;
	localparam int TIME_W   = 64;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// default number of entries
	localparam int DEFAULT_DEPTH = 16;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

### rtl/alarm_sorted_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | handshake           | payload
// --------+-----------+---------------------+-------------------------------------------
// in      | input     | in_valid / in_ready | mode, task_id, wake_time
// out     | output    | out_valid/out_ready | status, taken_id, head_id, tail_id, count
//
// one word in, one word out; a word is taken only while the sequencer is idle
// push: entries later than the new one move one slot toward the tail, then it is written
// pop takes slot zero, remove scans from zero for the id; later entries move back one slot
// every word then reads head and tail through the registered ram read port, unless empty
// reset clears count and control state; entry ram is never cleared, only entries
// below count are ever read; a stalled result holds in the output register

module alarm_sorted_priority_queue #(
	parameter int QUEUE_DEPTH = aspq_pkg::DEFAULT_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [aspq_pkg::MODE_W-1:0]      mode,
	input  wire logic [aspq_pkg::ID_W-1:0]        task_id,
	input  wire logic [aspq_pkg::TIME_W-1:0]      wake_time,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic      [aspq_pkg::STATUS_W-1:0]    status,
	output logic      [aspq_pkg::ID_W-1:0]        taken_id,
	output logic      [aspq_pkg::ID_W-1:0]        head_id,
	output logic      [aspq_pkg::ID_W-1:0]        tail_id,
	output logic      [aspq_pkg::COUNT_W-1:0]     count
);

	localparam int AW  = $clog2(QUEUE_DEPTH);
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int IW  = aspq_pkg::ID_W;
	localparam int TW  = aspq_pkg::TIME_W;
	localparam int EW  = IW + TW;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PUSH_RD,
		S_PUSH_CMP,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_GAP_RD,
		S_GAP_WR,
		S_HEAD,
		S_TAIL_RD,
		S_TAIL_WAIT,
		S_DONE
	} state_t;

	state_t                          state_q;
	logic [aspq_pkg::MODE_W-1:0]     mode_q;
	logic [IW-1:0]                   id_q;
	logic [TW-1:0]                   time_q;
	logic [AW-1:0]                   k_q;
	logic [CW-1:0]                   count_q;
	logic [aspq_pkg::STATUS_W-1:0]   status_q;
	logic [IW-1:0]                   taken_q;
	logic [IW-1:0]                   head_q;
	logic [IW-1:0]                   tail_q;

	// entry ram: {id, wake time}
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;

	logic [IW-1:0] rd_id;
	logic [TW-1:0] rd_time;
	logic          in_fire;
	logic          out_free;
	logic          key_less;
	logic          gap_more;
	logic          scan_last;

	assign rd_id     = ram_rdata[EW-1:TW];
	assign rd_time   = ram_rdata[TW-1:0];
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid || out_ready;
	// shared compare: new key strictly earlier than the entry just read
	assign key_less  = time_q < rd_time;
	// another entry remains behind position k
	assign gap_more  = (CW'(k_q) + CW'(1)) < count_q;
	assign scan_last = (CW'(k_q) + CW'(1)) == count_q;

	assign in_ready = (state_q == S_IDLE);

	aspq_ram #(
		.WIDTH(EW),
		.DEPTH(QUEUE_DEPTH)
	) u_entries (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// ram port steering per sequencer step
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = k_q;
		ram_wdata = {id_q, time_q};
		ram_raddr = k_q;
		case (state_q)
			S_PUSH_RD: begin
				if (k_q == '0) begin
					ram_we = 1'b1;
				end
				ram_raddr = k_q - AW'(1);
			end
			S_PUSH_CMP: begin
				// shift the later entry up one slot, or drop the new one in
				ram_we = 1'b1;
				if (key_less) begin
					ram_wdata = ram_rdata;
				end
			end
			S_GAP_RD: begin
				ram_raddr = k_q + AW'(1);
			end
			S_GAP_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			S_HEAD: begin
				ram_raddr = '0;
			end
			S_TAIL_RD: begin
				ram_raddr = AW'(count_q - CW'(1));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			// a new word in the done step takes over the slot instead
			if (out_valid && out_ready && state_q != S_DONE) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						mode_q   <= mode;
						id_q     <= task_id;
						time_q   <= wake_time;
						status_q <= aspq_pkg::ST_OK;
						taken_q  <= '0;
						k_q      <= '0;
						case (mode)
							aspq_pkg::MODE_PUSH: begin
								if (count_q == CW'(QUEUE_DEPTH)) begin
									status_q <= aspq_pkg::ST_FULL;
									state_q  <= S_HEAD;
								end else begin
									k_q     <= AW'(count_q);
									state_q <= S_PUSH_RD;
								end
							end
							aspq_pkg::MODE_POP,
							aspq_pkg::MODE_REMOVE: begin
								if (count_q == '0) begin
									status_q <= aspq_pkg::ST_EMPTY;
									state_q  <= S_HEAD;
								end else begin
									state_q <= S_SCAN_RD;
								end
							end
							aspq_pkg::MODE_CLEAR: begin
								count_q <= '0;
								state_q <= S_HEAD;
							end
							default: begin
								// query and unused codes leave the queue as is
								state_q <= S_HEAD;
							end
						endcase
					end
				end
				S_PUSH_RD: begin
					if (k_q == '0) begin
						count_q <= count_q + CW'(1);
						state_q <= S_HEAD;
					end else begin
						state_q <= S_PUSH_CMP;
					end
				end
				S_PUSH_CMP: begin
					if (key_less) begin
						k_q     <= k_q - AW'(1);
						state_q <= S_PUSH_RD;
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= S_HEAD;
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CHK;
				end
				S_SCAN_CHK: begin
					// pop always takes slot zero
					if (mode_q == aspq_pkg::MODE_POP || rd_id == id_q) begin
						taken_q <= rd_id;
						state_q <= S_GAP_RD;
					end else if (scan_last) begin
						status_q <= aspq_pkg::ST_EMPTY;
						state_q  <= S_HEAD;
					end else begin
						k_q     <= k_q + AW'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_GAP_RD: begin
					if (gap_more) begin
						state_q <= S_GAP_WR;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= S_HEAD;
					end
				end
				S_GAP_WR: begin
					k_q     <= k_q + AW'(1);
					state_q <= S_GAP_RD;
				end
				S_HEAD: begin
					if (count_q == '0) begin
						head_q  <= '0;
						tail_q  <= '0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_TAIL_RD;
					end
				end
				S_TAIL_RD: begin
					head_q  <= rd_id;
					state_q <= S_TAIL_WAIT;
				end
				S_TAIL_WAIT: begin
					tail_q  <= rd_id;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid <= 1'b1;
						status    <= status_q;
						taken_id  <= taken_q;
						head_id   <= head_q;
						tail_id   <= tail_q;
						count     <= aspq_pkg::COUNT_W'(count_q);
						state_q   <= S_IDLE;
					end else if (out_valid && out_ready) begin
						out_valid <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// fill level never passes the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("entry count above queue depth");

	// a dropped push is only reported when the queue is full
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == aspq_pkg::ST_FULL |-> count == aspq_pkg::COUNT_W'(QUEUE_DEPTH))
		else $error("full status with room left");

	// nothing is taken out unless the step succeeded
	a_taken_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != aspq_pkg::ST_OK |-> taken_id == '0)
		else $error("taken id set on failed step");

	// one word at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while busy");
`endif

endmodule

`default_nettype wire

### rtl/aspq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module aspq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire
